// ===== design/sequential_list_engine_unit_macros.svh =====
// Assertion macros of the list engine port checker
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sle_pkg.sv =====
// Types and constants of the list engine
package sle_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } sle_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } sle_status_t;

  localparam int         POS_W         = 5;
  localparam int         DATA_W        = 32;
  localparam logic [4:0] NOT_FOUND_POS = 5'h1f;

  typedef struct packed {
    sle_op_t                  op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     ins_ok;
    logic                     del_ok;
    logic                     load_hit;
  } sle_cmd_t;

endpackage

// ===== design/sle_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors, flags get and locate hits
module sle_cell #(
  parameter int PW = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sle_pkg::sle_cmd_t                 cmd,
  input  logic [PW-1:0]                     idx,
  input  logic [PW-1:0]                     count,
  input  logic signed [sle_pkg::DATA_W-1:0] prev_entry,
  input  logic signed [sle_pkg::DATA_W-1:0] next_entry,
  output logic signed [sle_pkg::DATA_W-1:0] entry,
  output logic                              hit
);

  logic signed [sle_pkg::DATA_W-1:0] entry_r, entry_nxt;
  logic                              hit_r, hit_nxt;
  logic [PW-1:0]                     pos_ext;

  assign pos_ext = PW'(cmd.position);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_ok) begin
      if (idx > pos_ext) begin
        entry_nxt = prev_entry;
      end else if (idx == pos_ext) begin
        entry_nxt = cmd.value;
      end
    end else if (cmd.del_ok) begin
      if (idx >= pos_ext) begin
        entry_nxt = next_entry;
      end
    end
  end

  always_comb begin
    hit_nxt = hit_r;
    if (cmd.load_hit) begin
      unique case (cmd.op)
        sle_pkg::OP_GET:    hit_nxt = (idx == pos_ext);
        sle_pkg::OP_LOCATE: hit_nxt = (entry_r == cmd.value) && (idx < count);
        default:            hit_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

// ===== design/sequential_list_engine_unit.sv =====
// Top level of the list engine: cell row, length counter and result register
// Ordered list of up to CAPACITY signed 32-bit entries packed from position 0, held one entry
// per cell in a row of cells. For each item the cells first shift for insert or delete and latch
// their get or locate hit flag; then, once the result register is free, the hit flags of the row
// are reduced into the result register. A new item is taken only after the previous one has
// reached the result register; a stalled result holds the next item in the cells and blocks
// further input. No clearing pass after reset.
module sequential_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [4:0]        in_position,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic signed [31:0] out_read_value,
  output logic signed [4:0] out_found_position,
  output logic [4:0]        out_list_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;
  localparam int IW = $clog2(CAPACITY);

  logic [CW-1:0]          count_r, count_nxt;
  logic                   busy_r;
  sle_pkg::sle_op_t       op_r;
  sle_pkg::sle_status_t   status_r, status_nxt;
  logic                   out_valid_r;
  sle_pkg::sle_status_t   out_status_r;
  logic signed [31:0]     out_read_value_r;
  logic [4:0]             out_found_position_r;
  logic [4:0]             out_list_length_r;

  logic                   accept, out_free, finish;
  sle_pkg::sle_op_t       in_op;
  logic [PW-1:0]          pos_ext, cnt_ext;
  sle_pkg::sle_cmd_t      cmd;

  logic signed [31:0]     ent [CAPACITY];
  logic                   hit [CAPACITY];

  logic                   any_hit;
  logic [IW-1:0]          hit_idx;
  logic signed [31:0]     rd_data;
  logic [PW-1:0]          hit_idx_ext, len_ext;

  assign in_op    = sle_pkg::sle_op_t'(in_opcode);
  assign out_free = !(out_valid_r && out_stall);
  assign in_stall = busy_r;
  assign accept   = in_valid && !in_stall;
  assign finish   = busy_r && out_free;

  assign pos_ext = PW'(in_position);
  assign cnt_ext = PW'(count_r);

  always_comb begin
    cmd.op       = in_op;
    cmd.position = in_position;
    cmd.value    = in_value;
    cmd.load_hit = accept;
    cmd.ins_ok   = accept && (in_op == sle_pkg::OP_INSERT) && (pos_ext <= cnt_ext)
                   && (cnt_ext < PW'(CAPACITY));
    cmd.del_ok   = accept && (in_op == sle_pkg::OP_DELETE) && (pos_ext < cnt_ext);
  end

  always_comb begin
    status_nxt = sle_pkg::ST_OK;
    unique case (in_op)
      sle_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_nxt = sle_pkg::ST_BADPOS;
        end else if (cnt_ext >= PW'(CAPACITY)) begin
          status_nxt = sle_pkg::ST_FULL;
        end
      end
      sle_pkg::OP_DELETE, sle_pkg::OP_GET: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = sle_pkg::ST_BADPOS;
        end
      end
      default: status_nxt = sle_pkg::ST_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.del_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = ent[0];
    end else begin : g_mid
      assign prev_e = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = ent[i];
    end else begin : g_body
      assign next_e = ent[i+1];
    end
    sle_cell #(.PW(PW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .idx        (PW'(i)),
      .count      (cnt_ext),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (ent[i]),
      .hit        (hit[i])
    );
  end

  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    rd_data = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = IW'(i);
      end
      rd_data = rd_data | (ent[i] & {32{hit[i]}});
    end
  end

  assign hit_idx_ext = PW'(hit_idx);
  assign len_ext     = PW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      status_r <= status_nxt;
    end
    if (finish) begin
      out_list_length_r <= len_ext[4:0];
      if (op_r == sle_pkg::OP_LOCATE) begin
        out_status_r         <= any_hit ? sle_pkg::ST_OK : sle_pkg::ST_NOTFOUND;
        out_found_position_r <= any_hit ? hit_idx_ext[4:0] : sle_pkg::NOT_FOUND_POS;
      end else begin
        out_status_r         <= status_r;
        out_found_position_r <= sle_pkg::NOT_FOUND_POS;
      end
      if ((op_r == sle_pkg::OP_GET) && (status_r == sle_pkg::ST_OK)) begin
        out_read_value_r <= rd_data;
      end else begin
        out_read_value_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_read_value_r;
  assign out_found_position = out_found_position_r;
  assign out_list_length    = out_list_length_r;

endmodule

// ===== design/sle_checker.sv =====
// Port-level checker of the list engine and its bind
`include "sequential_list_engine_unit_macros.svh"

module sle_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        in_opcode,
  input logic [4:0]        in_position,
  input logic signed [31:0] in_value,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic signed [31:0] out_read_value,
  input logic signed [4:0] out_found_position,
  input logic [4:0]        out_list_length
);

  `SLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_status), "stalled result changed")
  `SLE_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "item taken while another is at work")
  `SLE_ASSERT_NOW(a_notfound_pos, out_valid && (out_status == sle_pkg::ST_NOTFOUND), out_found_position == sle_pkg::NOT_FOUND_POS, "failed locate reports a position")
  `SLE_ASSERT_NOW(a_read_only_ok, out_valid && (out_read_value != 32'sd0), out_status == sle_pkg::ST_OK, "read data on a failed item")

endmodule

bind sequential_list_engine_unit sle_port_checker u_sle_checker (.*);

// ===== dv/sle_checker.sv =====
// List engine checker: predicts each item's result and compares it on the result channel
`timescale 1ns / 1ps

module sle_checker #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic signed [31:0] out_read_value,
  input  logic signed [4:0]  out_found_position,
  input  logic [4:0]         out_list_length,
  output int                 error_count,
  output int                 pending_count
);

  typedef struct packed {
    sle_pkg::sle_status_t status;
    logic signed [31:0]   read_value;
    logic [4:0]           found_position;
    logic [4:0]           list_length;
  } list_result_t;

  list_result_t       result_q[$];
  logic signed [31:0] list_words[CAPACITY];
  int                 list_len;

  initial begin
    error_count   = 0;
    pending_count = 0;
    list_len      = 0;
  end

  function automatic list_result_t apply_list_op(sle_pkg::sle_op_t op, logic [4:0] pos,
                                                 logic signed [31:0] val);
    list_result_t res;
    int           idx;
    res.status         = sle_pkg::ST_OK;
    res.read_value     = '0;
    res.found_position = sle_pkg::NOT_FOUND_POS;
    case (op)
      sle_pkg::OP_INSERT: begin
        if (int'(pos) > list_len) begin
          res.status = sle_pkg::ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          res.status = sle_pkg::ST_FULL;
        end else begin
          for (idx = list_len; idx > int'(pos); idx--) list_words[idx] = list_words[idx-1];
          list_words[pos] = val;
          list_len++;
        end
      end
      sle_pkg::OP_DELETE: begin
        if (int'(pos) >= list_len) begin
          res.status = sle_pkg::ST_BADPOS;
        end else begin
          for (idx = int'(pos); idx + 1 < list_len; idx++) list_words[idx] = list_words[idx+1];
          list_len--;
        end
      end
      sle_pkg::OP_GET: begin
        if (int'(pos) >= list_len) res.status = sle_pkg::ST_BADPOS;
        else res.read_value = list_words[pos];
      end
      default: begin
        res.status = sle_pkg::ST_NOTFOUND;
        for (idx = 0; idx < list_len; idx++) begin
          if (list_words[idx] == val) begin
            res.status         = sle_pkg::ST_OK;
            res.found_position = 5'(idx);
            break;
          end
        end
      end
    endcase
    res.list_length = 5'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      result_q.delete();
      list_len = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d data %h pos %h len %0d",
                   $time, out_status, out_read_value, out_found_position, out_list_length);
          error_count++;
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            error_count++;
          end
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     out_read_value);
            error_count++;
          end
          if (out_found_position !== want.found_position) begin
            $display("%0t: found_position expected %h actual %h", $time,
                     want.found_position, out_found_position);
            error_count++;
          end
          if (out_list_length !== want.list_length) begin
            $display("%0t: list_length expected %0d actual %0d", $time, want.list_length,
                     out_list_length);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        result_q.push_back(apply_list_op(sle_pkg::sle_op_t'(in_opcode), in_position,
                                         in_value));
    end
    pending_count = result_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the list engine: clock, reset, item stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int LIST_CAP     = 16;
  localparam int RANDOM_ITEMS = 1450;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [1:0]         in_opcode          = sle_pkg::OP_INSERT;
  logic [4:0]         in_position        = '0;
  logic signed [31:0] in_value           = '0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_read_value;
  logic signed [4:0]  out_found_position;
  logic [4:0]         out_list_length;
  int                 error_count;
  int                 pending_count;

  int                 est_len    = 0;
  int                 burst_left = 0;
  logic signed [31:0] value_pool[$];

  stall_mode_t        stall_mode = STALL_NONE;
  int                 stall_left = 0;
  logic [3:0]         stall_tick = '0;

  sequential_list_engine_unit #(.CAPACITY(LIST_CAP)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  sle_checker #(.CAPACITY(LIST_CAP)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length),
    .error_count        (error_count),
    .pending_count      (pending_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
      default:     out_stall <= stall_tick[2];
    endcase
    stall_tick <= stall_tick + 1'b1;
  end

  task automatic send_item(sle_pkg::sle_op_t op, logic [4:0] pos, logic signed [31:0] val);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (in_stall);
    if (op == sle_pkg::OP_INSERT && int'(pos) <= est_len && est_len < LIST_CAP) begin
      est_len++;
      value_pool.push_back(val);
      if (value_pool.size() > 8) void'(value_pool.pop_front());
    end else if (op == sle_pkg::OP_DELETE && int'(pos) < est_len) begin
      est_len--;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  function automatic logic signed [31:0] pick_value(bit for_locate);
    int pick;
    pick = $urandom_range(0, 99);
    if (for_locate && pick < 50 && value_pool.size() > 0)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    if (pick < 70) return $urandom_range(0, 7);
    if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [4:0] pick_position(sle_pkg::sle_op_t op);
    if ($urandom_range(0, 99) < 20) return 5'($urandom_range(0, LIST_CAP));
    if (op == sle_pkg::OP_INSERT) return 5'($urandom_range(0, est_len));
    if (est_len == 0 || $urandom_range(0, 9) == 0) return 5'(est_len);
    return 5'($urandom_range(0, est_len - 1));
  endfunction

  initial begin
    sle_pkg::sle_op_t op;
    int               ins_pct;
    int               del_pct;
    int               segment_left;
    int               pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(sle_pkg::OP_GET, 5'd0, 32'sd0);
    send_item(sle_pkg::OP_DELETE, 5'd0, 32'sd0);
    send_item(sle_pkg::OP_LOCATE, 5'd0, 32'sd0);
    send_item(sle_pkg::OP_INSERT, 5'd1, 32'sd9);
    for (int i = 0; i < LIST_CAP; i++) begin
      case (i)
        0:       send_item(sle_pkg::OP_INSERT, 5'd0, 32'sh8000_0000);
        1:       send_item(sle_pkg::OP_INSERT, 5'd1, 32'sh7fff_ffff);
        2, 3:    send_item(sle_pkg::OP_INSERT, 5'(i), 32'sh55);
        default: send_item(sle_pkg::OP_INSERT, (i % 2) ? 5'(i / 2) : 5'd0,
                           32'(i) * 32'h0101_0101);
      endcase
    end
    send_item(sle_pkg::OP_INSERT, 5'd16, 32'sd1);
    send_item(sle_pkg::OP_GET, 5'd15, 32'sd0);
    send_item(sle_pkg::OP_GET, 5'd16, 32'sd0);
    send_item(sle_pkg::OP_LOCATE, 5'd0, 32'sh55);
    send_item(sle_pkg::OP_DELETE, 5'd15, 32'sd0);

    segment_left = 0;
    ins_pct      = 30;
    del_pct      = 25;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(40, 120);
        case ($urandom_range(0, 2))
          0: begin ins_pct = 60; del_pct = 15; end
          1: begin ins_pct = 15; del_pct = 50; end
          default: begin ins_pct = 30; del_pct = 25; end
        endcase
      end
      segment_left--;
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) op = sle_pkg::OP_INSERT;
      else if (pick < ins_pct + del_pct) op = sle_pkg::OP_DELETE;
      else if (pick < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) op = sle_pkg::OP_GET;
      else op = sle_pkg::OP_LOCATE;
      send_item(op, pick_position(op), pick_value(op == sle_pkg::OP_LOCATE));
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
